// File: rtl/msd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants of the masked 2x2 downsample unit
// Field widths, register indexes, pair store entry and request layouts.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 2048;

    localparam int unsigned SAMPLE_W   = 32;
    localparam int unsigned GEOM_W     = 12;
    localparam int unsigned DEST_W     = 11;
    localparam int unsigned PAIR_W     = SAMPLE_W + 1;
    localparam int unsigned TOTAL_W    = SAMPLE_W + 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUADRANT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVALID_CHECK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVALID_VALUE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_NEAREST = 3'd5;

    // quadrant bits
    localparam int unsigned QUAD_RIGHT = 0;
    localparam int unsigned QUAD_LOWER = 1;

    // ceil(2^35 / 3): floor(x * RECIP3 / 2^35) == floor(x / 3) for x < 2^35
    localparam int unsigned  RECIP3_SHIFT = 35;
    localparam logic [33:0]  RECIP3       = 34'd11453246123;

    // upper-row pair: sum of valid samples and how many were valid
    typedef struct packed {
        logic [1:0]        count;
        logic [PAIR_W-1:0] sum;
    } entry_t;

    // lower-row pair sent into the averaging pipe
    typedef struct packed {
        logic [PAIR_W-1:0] pair_sum;
        logic [1:0]        pair_n;
        logic [DEST_W-1:0] dest_x;
        logic [DEST_W-1:0] dest_y;
        logic              last;
    } req_t;

endpackage

`default_nettype wire

// File: rtl/masked_2x2_downsample_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_2x2_downsample_unit: masked 2x2 box downsample of a raster stream
// Averages each aligned 2x2 block of valid samples into one result placed
// in the chosen quadrant of a destination the size of the source grid.
// ----------------------------------------------------------------------------
//
//  channel   direction  fields (lowest bit up)
//  s_axis    in         tdata: sample[31:0]
//  m_axis    out        tdata: dest_x[10:0], dest_y[21:11], average[53:22], pad
//                       tuser: is_valid; tlast: frame_end
//  cfg       in         cfg_we, cfg_index, cfg_wdata (write only)
//
//  One sample per clock is accepted while the result side keeps up; a
//  result passes the stage 1 to stage 4 registers and then the output
//  register. The rate is set by the single pair store port pair used per
//  sample (one write on upper rows, one read on lower rows).
//  Reset clears counters, the left-sample hold and pipe valids; the pair
//  store needs no clearing, since every frame writes a row before reading.
//  A stall on m_tready fills the pipe stages and then drops s_tready.
//
module masked_2x2_downsample_unit #(
    parameter int unsigned MAX_WIDTH  = msd_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = msd_pkg::MAX_HEIGHT_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // input stream
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [31:0]                    s_tdata,   // sample[31:0]
    // result stream
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [55:0]                   m_tdata,   // dest_x, dest_y, average, pad
    output logic [0:0]                    m_tuser,   // is_valid
    output logic                          m_tlast,   // frame_end
    // configuration writes
    input  wire                           cfg_we,
    input  wire [msd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [msd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import msd_pkg::*;

    localparam int unsigned CW    = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
    localparam int unsigned RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned DEPTH = MAX_WIDTH / 2;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // compare width: holds a counter plus one and any register value
    localparam int unsigned CMPW  = ((CW > RW ? CW : RW) + 1 > GEOM_W)
                                    ? (CW > RW ? CW : RW) + 1 : GEOM_W;
    localparam int unsigned DXC   = CMPW + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [GEOM_W-1:0]   grid_width_reg, grid_height_reg;
    logic [1:0]          quadrant_reg;
    logic                invalid_check_reg, round_nearest_reg;
    logic [SAMPLE_W-1:0] invalid_value_reg;
    logic                geom_write;

    assign geom_write = cfg_we && (cfg_index == REG_GRID_WIDTH ||
                                   cfg_index == REG_GRID_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg    <= GEOM_W'(2048);
            grid_height_reg   <= GEOM_W'(2048);
            quadrant_reg      <= 2'd0;
            invalid_check_reg <= 1'b1;
            invalid_value_reg <= '0;
            round_nearest_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRID_WIDTH:    grid_width_reg    <= cfg_wdata[GEOM_W-1:0];
                REG_GRID_HEIGHT:   grid_height_reg   <= cfg_wdata[GEOM_W-1:0];
                REG_QUADRANT:      quadrant_reg      <= cfg_wdata[1:0];
                REG_INVALID_CHECK: invalid_check_reg <= cfg_wdata[0];
                REG_INVALID_VALUE: invalid_value_reg <= cfg_wdata[SAMPLE_W-1:0];
                REG_ROUND_NEAREST: round_nearest_reg <= cfg_wdata[0];
                default: ;  // writes beyond the register list are ignored
            endcase
        end
    end

    // even sizes within the store and row limits only; otherwise drop samples
    logic geom_ok;
    assign geom_ok = (grid_width_reg  >= GEOM_W'(2)) && !grid_width_reg[0]
                  && (32'(grid_width_reg)  <= 32'(MAX_WIDTH))
                  && (grid_height_reg >= GEOM_W'(2)) && !grid_height_reg[0]
                  && (32'(grid_height_reg) <= 32'(MAX_HEIGHT));

    // ------------------------------------------------------------------
    // raster position
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CMPW-1:0] col_inc, row_inc;
    logic            col_wrap, row_wrap;
    logic            accept;
    logic            pipe_ready;

    assign s_tready = pipe_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        col_inc  = CMPW'(col_reg) + CMPW'(1);
        row_inc  = CMPW'(row_reg) + CMPW'(1);
        col_wrap = col_inc >= CMPW'(grid_width_reg);
        row_wrap = row_inc >= CMPW'(grid_height_reg);
        if (col_wrap) begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_inc[RW-1:0];
        end else begin
            col_next = col_inc[CW-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (geom_write) begin
            // restart the frame on a geometry change
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (geom_ok) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end else begin
                col_reg <= '0;
                row_reg <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // sample masking and horizontal pair
    // ------------------------------------------------------------------
    logic                sample_ok;
    logic [SAMPLE_W-1:0] left_val_reg;
    logic                left_ok_reg;
    logic                odd_col, lower_row, work;

    assign sample_ok = !(invalid_check_reg && (s_tdata == invalid_value_reg));
    assign odd_col   = col_reg[0];
    assign lower_row = row_reg[0];
    assign work      = accept && geom_ok;

    // hold the left sample of the pair until its right neighbor arrives
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_val_reg <= '0;
            left_ok_reg  <= 1'b0;
        end else if (work && !odd_col) begin
            left_val_reg <= sample_ok ? s_tdata : '0;
            left_ok_reg  <= sample_ok;
        end
    end

    logic [PAIR_W-1:0] left_ext, right_ext;
    entry_t            pair_entry;
    logic [CW-1:0]     col_half;
    logic [AW-1:0]     slot;

    always_comb begin
        left_ext         = left_ok_reg ? {left_val_reg[SAMPLE_W-1], left_val_reg} : '0;
        right_ext        = sample_ok   ? {s_tdata[SAMPLE_W-1], s_tdata}           : '0;
        pair_entry.sum   = left_ext + right_ext;
        pair_entry.count = {1'b0, left_ok_reg} + {1'b0, sample_ok};
        col_half         = col_reg >> 1;
        slot             = col_half[AW-1:0];
    end

    // ------------------------------------------------------------------
    // pair store: upper rows write, lower rows read one row later, so an
    // entry is never written and read in overlapping cycles
    // ------------------------------------------------------------------
    logic   store_we, store_re;
    entry_t store_rdata;

    assign store_we = work && odd_col && !lower_row;
    assign store_re = work && odd_col &&  lower_row;

    msd_pair_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pair_ram (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (slot),
        .wdata (pair_entry),
        .re    (store_re),
        .raddr (slot),
        .rdata (store_rdata)
    );

    // ------------------------------------------------------------------
    // destination position and frame end of the lower-right sample
    // ------------------------------------------------------------------
    logic [DXC-1:0] dx_full, dy_full;
    req_t           req;

    always_comb begin
        dx_full = DXC'(col_half)
                + (quadrant_reg[QUAD_RIGHT] ? DXC'(grid_width_reg >> 1)  : DXC'(0));
        dy_full = DXC'(row_reg >> 1)
                + (quadrant_reg[QUAD_LOWER] ? DXC'(grid_height_reg >> 1) : DXC'(0));
        req.pair_sum = pair_entry.sum;
        req.pair_n   = pair_entry.count;
        req.dest_x   = dx_full[DEST_W-1:0];
        req.dest_y   = dy_full[DEST_W-1:0];
        req.last     = col_wrap && row_wrap;
    end

    // ------------------------------------------------------------------
    // averaging pipe and output register
    // ------------------------------------------------------------------
    msd_avg_pipe u_avg_pipe (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (store_re),
        .in_ready      (pipe_ready),
        .in_req        (req),
        .rd_entry      (store_rdata),
        .round_nearest (round_nearest_reg),
        .invalid_value (invalid_value_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/msd_pair_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_pair_ram: upper-row pair store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msd_pair_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire               aclk,
    input  wire               we,
    input  wire [AW-1:0]      waddr,
    input  msd_pkg::entry_t   wdata,
    input  wire               re,
    input  wire [AW-1:0]      raddr,
    output msd_pkg::entry_t   rdata
);
    import msd_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/msd_avg_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_avg_pipe: block sum, divide by valid count, output register
// Four stages plus the output register; each stage advances when the one
// after it is empty or moving.
// ----------------------------------------------------------------------------
module msd_avg_pipe (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  msd_pkg::req_t              in_req,
    input  msd_pkg::entry_t            rd_entry,
    input  wire                        round_nearest,
    input  wire [msd_pkg::SAMPLE_W-1:0] invalid_value,
    output logic                       m_tvalid,
    input  wire                        m_tready,
    output logic [55:0]                m_tdata,
    output logic [0:0]                 m_tuser,
    output logic                       m_tlast
);
    import msd_pkg::*;

    typedef struct packed {
        logic [DEST_W-1:0] dest_x;
        logic [DEST_W-1:0] dest_y;
        logic              last;
        logic              neg;
        logic [2:0]        n;
    } meta_t;

    // stage registers
    logic        s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, out_v_reg;
    req_t        s1_req_reg;
    meta_t       s2_meta_reg, s3_meta_reg, s4_meta_reg;
    logic [33:0] s2_x_reg;
    logic [50:0] s3_pp_hi_reg, s3_pp_lo_reg;
    logic [33:0] s3_qshift_reg;
    logic [33:0] s4_q_reg;
    logic [DEST_W-1:0]   out_dx_reg, out_dy_reg;
    logic [SAMPLE_W-1:0] out_avg_reg;
    logic                out_ok_reg, out_last_reg;

    logic out_adv, s4_adv, s3_adv, s2_adv, s1_adv;

    assign out_adv  = !out_v_reg || m_tready;
    assign s4_adv   = !s4_v_reg  || out_adv;
    assign s3_adv   = !s3_v_reg  || s4_adv;
    assign s2_adv   = !s2_v_reg  || s3_adv;
    assign s1_adv   = !s1_v_reg  || s2_adv;
    assign in_ready = s1_adv;

    // stage 1: add both pairs, take magnitude, add rounding offset
    logic [TOTAL_W-1:0] s1_total;
    logic [2:0]         s1_n;
    logic               s1_neg;
    logic [33:0]        s1_mag, s1_x_next;
    logic [1:0]         s1_addend;

    always_comb begin
        s1_total  = {s1_req_reg.pair_sum[PAIR_W-1], s1_req_reg.pair_sum}
                  + {rd_entry.sum[PAIR_W-1], rd_entry.sum};
        s1_n      = {1'b0, s1_req_reg.pair_n} + {1'b0, rd_entry.count};
        s1_neg    = s1_total[TOTAL_W-1];
        s1_mag    = s1_neg ? (~s1_total + 34'd1) : s1_total;
        s1_addend = round_nearest ? s1_n[2:1] : 2'd0;
        s1_x_next = s1_mag + {32'd0, s1_addend};
    end

    // stage 2: partial products for the divide by three, shifts for two and four
    logic [50:0] s2_pp_hi_next, s2_pp_lo_next;
    logic [33:0] s2_qshift_next;

    always_comb begin
        s2_pp_hi_next = 51'(s2_x_reg[33:17]) * 51'(RECIP3);
        s2_pp_lo_next = 51'(s2_x_reg[16:0])  * 51'(RECIP3);
        case (s2_meta_reg.n)
            3'd2:    s2_qshift_next = s2_x_reg >> 1;
            3'd4:    s2_qshift_next = s2_x_reg >> 2;
            default: s2_qshift_next = s2_x_reg;
        endcase
    end

    // stage 3: combine partial products, pick the divide by three or shifted quotient
    logic [67:0] s3_full;
    logic [33:0] s3_q_next;

    always_comb begin
        s3_full   = {s3_pp_hi_reg, 17'd0} + {17'd0, s3_pp_lo_reg};
        s3_q_next = (s3_meta_reg.n == 3'd3) ? {1'b0, s3_full[67:RECIP3_SHIFT]}
                                            : s3_qshift_reg;
    end

    // stage 4: restore sign, substitute marker when nothing was valid
    logic [33:0]         s4_signed;
    logic [SAMPLE_W-1:0] s4_avg_next;

    always_comb begin
        s4_signed   = s4_meta_reg.neg ? (~s4_q_reg + 34'd1) : s4_q_reg;
        s4_avg_next = (s4_meta_reg.n == 3'd0) ? invalid_value : s4_signed[SAMPLE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (s1_adv)  s1_v_reg  <= in_valid;
            if (s2_adv)  s2_v_reg  <= s1_v_reg;
            if (s3_adv)  s3_v_reg  <= s2_v_reg;
            if (s4_adv)  s4_v_reg  <= s3_v_reg;
            if (out_adv) out_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && in_valid) begin
            s1_req_reg <= in_req;
        end
        if (s2_adv && s1_v_reg) begin
            s2_x_reg           <= s1_x_next;
            s2_meta_reg.dest_x <= s1_req_reg.dest_x;
            s2_meta_reg.dest_y <= s1_req_reg.dest_y;
            s2_meta_reg.last   <= s1_req_reg.last;
            s2_meta_reg.neg    <= s1_neg;
            s2_meta_reg.n      <= s1_n;
        end
        if (s3_adv && s2_v_reg) begin
            s3_pp_hi_reg  <= s2_pp_hi_next;
            s3_pp_lo_reg  <= s2_pp_lo_next;
            s3_qshift_reg <= s2_qshift_next;
            s3_meta_reg   <= s2_meta_reg;
        end
        if (s4_adv && s3_v_reg) begin
            s4_q_reg    <= s3_q_next;
            s4_meta_reg <= s3_meta_reg;
        end
        if (out_adv && s4_v_reg) begin
            out_dx_reg   <= s4_meta_reg.dest_x;
            out_dy_reg   <= s4_meta_reg.dest_y;
            out_avg_reg  <= s4_avg_next;
            out_ok_reg   <= (s4_meta_reg.n != 3'd0);
            out_last_reg <= s4_meta_reg.last;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {2'b00, out_avg_reg, out_dy_reg, out_dx_reg};
    assign m_tuser  = out_ok_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
